@@ design/median_of_sample_set_unit_defines.svh @@
// Assertion macros for the median unit checker.
// No dependencies; include by bare file name.
`ifndef MEDIAN_OF_SAMPLE_SET_UNIT_DEFINES_SVH
`define MEDIAN_OF_SAMPLE_SET_UNIT_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define MED_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("median unit check failed");

// Next-cycle implication under an active-low reset.
`define MED_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("median unit check failed");

`endif

@@ design/med_pkg.sv @@
// Shared constants, types and state encoding for the median unit.
// No dependencies.
package med_pkg;

    localparam int MAX_SAMPLES   = 16;
    localparam int SAMPLE_W      = 32;
    localparam int CNT_W         = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W        = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int COUNT_FIELD_W = 5;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 40;
    localparam int OUT_PAD_W     = OUT_TDATA_W - SAMPLE_W - COUNT_FIELD_W;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_LOADC,
        ENG_CAPT,
        ENG_SCAN,
        ENG_SUM,
        ENG_DONE
    } eng_state_t;

    // Closed set handed to the selection engine.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        logic             dropped;
    } eng_start_t;

    // Finished median offered by the engine.
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] median;
        logic [CNT_W-1:0]           count;
        logic                       dropped;
    } eng_result_t;

endpackage

@@ design/med_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module med_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/med_sel.sv @@
// Rank-count selection engine: finds the middle sorted value(s) of a set in RAM.
// Depends on med_pkg; reads the sample RAM through one registered read port.
module med_sel (
    input  logic                          clk,
    input  logic                          rst_n,
    input  med_pkg::eng_start_t           start_in,
    output logic                          idle,
    output logic [med_pkg::ADDR_W-1:0]    raddr,
    input  logic [med_pkg::SAMPLE_W-1:0]  rdata,
    output med_pkg::eng_result_t          result,
    input  logic                          result_ack
);
    import med_pkg::*;

    eng_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]           n_reg;
    logic                       drop_reg;
    logic [CNT_W-1:0]           i_reg;
    logic [CNT_W-1:0]           j_reg;
    logic [CNT_W-1:0]           lt_reg;
    logic [CNT_W-1:0]           le_reg;
    logic signed [SAMPLE_W-1:0] cand_reg;
    logic signed [SAMPLE_W-1:0] vk_reg;
    logic signed [SAMPLE_W-1:0] vk1_reg;
    logic signed [SAMPLE_W:0]   sum_reg;

    logic signed [SAMPLE_W-1:0] x;
    logic [CNT_W-1:0]           lt_new;
    logic [CNT_W-1:0]           le_new;
    logic [CNT_W-1:0]           k;
    logic [CNT_W-1:0]           k1;
    logic                       n_even;
    logic                       scan_end;
    logic                       cand_end;

    assign x        = $signed(rdata);
    assign lt_new   = lt_reg + CNT_W'(x < cand_reg);
    assign le_new   = le_reg + CNT_W'(x <= cand_reg);
    assign k        = n_reg >> 1;
    assign k1       = k - CNT_W'(1);
    assign n_even   = ~n_reg[0];
    assign scan_end = (j_reg == n_reg - CNT_W'(1));
    assign cand_end = (i_reg == n_reg - CNT_W'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE:  if (start_in.start) state_next = ENG_LOADC;
            ENG_LOADC: state_next = ENG_CAPT;
            ENG_CAPT:  state_next = ENG_SCAN;
            ENG_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = cand_end ? ENG_SUM : ENG_LOADC;
                end
            end
            ENG_SUM:   state_next = ENG_DONE;
            ENG_DONE:  if (result_ack) state_next = ENG_IDLE;
            default:   state_next = ENG_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        idle           = 1'b0;
        raddr          = i_reg[ADDR_W-1:0];
        result.valid   = 1'b0;
        result.median  = sum_reg[SAMPLE_W:1] + SAMPLE_W'(sum_reg[SAMPLE_W] & sum_reg[0]);
        result.count   = n_reg;
        result.dropped = drop_reg;
        case (state_reg)
            ENG_IDLE:  idle = 1'b1;
            ENG_LOADC: raddr = i_reg[ADDR_W-1:0];
            ENG_CAPT:  raddr = '0;
            ENG_SCAN:  raddr = ADDR_W'(j_reg + CNT_W'(1));
            ENG_SUM:   raddr = i_reg[ADDR_W-1:0];
            ENG_DONE:  result.valid = 1'b1;
            default:   idle = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ENG_IDLE:
            begin
                n_reg    <= start_in.count;
                drop_reg <= start_in.dropped;
                i_reg    <= '0;
            end
            ENG_CAPT:
            begin
                cand_reg <= x;
                j_reg    <= '0;
                lt_reg   <= '0;
                le_reg   <= '0;
            end
            ENG_SCAN:
            begin
                j_reg  <= j_reg + CNT_W'(1);
                lt_reg <= lt_new;
                le_reg <= le_new;
                if (scan_end)
                begin
                    // candidate covers sorted positions lt_new .. le_new-1
                    if (lt_new <= k && k < le_new)
                    begin
                        vk_reg <= cand_reg;
                    end
                    if (n_even && lt_new <= k1 && k1 < le_new)
                    begin
                        vk1_reg <= cand_reg;
                    end
                    i_reg <= i_reg + CNT_W'(1);
                end
            end
            ENG_SUM:
            begin
                if (n_even)
                begin
                    sum_reg <= (SAMPLE_W + 1)'(vk_reg) + (SAMPLE_W + 1)'(vk1_reg);
                end
                else
                begin
                    sum_reg <= (SAMPLE_W + 1)'(vk_reg) + (SAMPLE_W + 1)'(vk_reg);
                end
            end
            default:
            begin
                cand_reg <= cand_reg;
            end
        endcase
    end

endmodule

@@ design/median_of_sample_set_unit.sv @@
// Top level of the median unit: sample intake, sample RAM, selection engine, result beat.
// Depends on med_pkg, med_ram and med_sel.
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  s_axis  | in  | tdata: sample[31:0]; tlast: closes the set
//  m_axis  | out | tdata: median[31:0], sample_count[36:32], zero pad [39:37];
//          |     | tuser: overflow
//
//  Intake takes one sample beat per cycle while no set is being resolved.
//  After the closing beat, the engine resolves the set of n stored samples:
//  every sample is ranked against all others through the single registered
//  read port of the sample RAM, one comparison a cycle, then state SUM forms
//  the middle sum and state DONE hands it to the output register.
//  If the output register still holds an unaccepted beat, engine and intake stall.
//  Reset (rst_n, async, active low) clears counts, flags and valids; the
//  RAM needs no clearing since only entries of the current set are read.
module median_of_sample_set_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [med_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [31:0] sample
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [med_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [31:0] median, [36:32] count
    output logic                                m_axis_tuser   // [0] overflow
);
    import med_pkg::*;

    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      drop_reg, drop_next;
    logic                      in_beat;
    logic                      has_room;
    logic                      eng_idle;
    logic [ADDR_W-1:0]         eng_raddr;
    logic [SAMPLE_W-1:0]       ram_rdata;
    eng_start_t                eng_start;
    eng_result_t               eng_res;
    logic                      slot_free;
    logic                      res_take;

    logic                      out_valid_reg;
    logic [SAMPLE_W-1:0]       out_median_reg;
    logic [COUNT_FIELD_W-1:0]  out_count_reg;
    logic                      out_drop_reg;

    // Hold off intake while a closed set is being resolved.
    assign s_axis_tready = eng_idle;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign has_room      = (cnt_reg < CNT_W'(MAX_SAMPLES));

    always_comb
    begin
        cnt_next  = has_room ? cnt_reg + CNT_W'(1) : cnt_reg;
        drop_next = drop_reg | ~has_room;
    end

    // Closing beat hands the set size and drop flag to the engine.
    assign eng_start.start   = in_beat && s_axis_tlast;
    assign eng_start.count   = cnt_next;
    assign eng_start.dropped = drop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            if (s_axis_tlast)
            begin
                cnt_reg  <= '0;
                drop_reg <= 1'b0;
            end
            else
            begin
                cnt_reg  <= cnt_next;
                drop_reg <= drop_next;
            end
        end
    end

    // Store the sample at the fill position; drop it when the RAM is full.
    med_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .clk   (clk),
        .we    (in_beat && has_room),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (s_axis_tdata[SAMPLE_W-1:0]),
        .raddr (eng_raddr),
        .rdata (ram_rdata)
    );

    med_sel u_sel (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_in   (eng_start),
        .idle       (eng_idle),
        .raddr      (eng_raddr),
        .rdata      (ram_rdata),
        .result     (eng_res),
        .result_ack (res_take)
    );

    // Advance the result into the output register once it is empty or draining.
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign res_take  = eng_res.valid && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= eng_res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_median_reg <= eng_res.median;
            out_count_reg  <= COUNT_FIELD_W'(eng_res.count);
            out_drop_reg   <= eng_res.dropped;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {OUT_PAD_W'(0), out_count_reg, out_median_reg};
    assign m_axis_tuser  = out_drop_reg;

endmodule

@@ design/med_chk.sv @@
// Port-level checker for the median unit, bound to the top level.
// Depends on med_pkg and median_of_sample_set_unit_defines.svh.
`include "median_of_sample_set_unit_defines.svh"

module med_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [med_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);
    import med_pkg::*;

    logic [COUNT_FIELD_W-1:0] cnt_f;
    logic [OUT_TDATA_W:0]     out_word;
    logic                     out_stall;
    logic                     ovf_beat;
    logic                     s_last_beat;

    assign cnt_f       = m_axis_tdata[SAMPLE_W +: COUNT_FIELD_W];
    assign out_word    = {m_axis_tuser, m_axis_tdata};
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign ovf_beat    = m_axis_tvalid && m_axis_tuser;
    assign s_last_beat = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    // A stalled result beat holds.
    `MED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))
    // Every result covers at least one sample.
    `MED_ASSERT_NOW(a_count_nonzero, clk, rst_n, m_axis_tvalid, cnt_f != '0)
    // Overflow only with a full store.
    `MED_ASSERT_NOW(a_ovf_full, clk, rst_n, ovf_beat, cnt_f == COUNT_FIELD_W'(MAX_SAMPLES))
    // Intake pauses after a closing beat.
    `MED_ASSERT_NEXT(a_close_pause, clk, rst_n, s_last_beat, !s_axis_tready)

endmodule

bind median_of_sample_set_unit med_chk u_med_chk (.*);
